// File: rtl/mvhm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvhm_pkg
// Shared widths, action codes, table entry layout and controller states for
// the min-value hash map.
// ----------------------------------------------------------------------------
package mvhm_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 31;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // bucket hash: h = (h * HASH_MUL + digit) mod BUCKETS, least significant digit first
  localparam int unsigned HASH_MUL = 13;
  localparam int unsigned RADIX    = 10;

  // k / 10 == (k * DIV10_MUL) >> DIV10_SHIFT, exact for every k below 2**32
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_MODIFY,
    ST_CLEAR,
    ST_PUSH
  } state_t;

endpackage
`default_nettype wire

// File: rtl/mvhm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvhm_in_if
// Request channel: action, key and offered value with valid/ready.
// ----------------------------------------------------------------------------
interface mvhm_in_if;
  import mvhm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/mvhm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvhm_out_if
// Result channel: found flag, stored value and overflow flag with valid/ready.
// ----------------------------------------------------------------------------
interface mvhm_out_if;
  import mvhm_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] stored_value;
  logic             overflow;

  modport source (output valid, output found, output stored_value, output overflow,
                  input ready);
  modport sink   (input valid, input found, input stored_value, input overflow,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/mvhm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvhm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mvhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/mvhm_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvhm_hash
// Iterative bucket hash over the decimal digits of a key, one digit per cycle.
// ----------------------------------------------------------------------------
module mvhm_hash #(
  parameter int BUCKETS = 307
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  input  wire logic [mvhm_pkg::KEY_W-1:0]                 key,
  output logic                                            done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
  import mvhm_pkg::*;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int XW    = BKT_W + 5;

  logic             busy_r, busy_nxt;
  logic [KEY_W-1:0] k_r, k_nxt;
  logic [BKT_W-1:0] h_r, h_nxt;

  logic [63:0]      prod;
  logic [63:0]      q_full;
  logic [KEY_W-1:0] q;
  logic [KEY_W-1:0] q10;
  logic [KEY_W-1:0] rem_full;
  logic [XW-1:0]    x;
  logic [XW-1:0]    x_mod;

  // peel one digit: q = k / 10, digit = k - 10q
  always_comb begin
    prod     = 64'({1'b0, k_r}) * 64'(DIV10_MUL);
    q_full   = prod >> DIV10_SHIFT;
    q        = q_full[KEY_W-1:0];
    q10      = q * KEY_W'(RADIX);
    rem_full = k_r - q10;
    x        = XW'(h_r) * XW'(HASH_MUL) + XW'(rem_full[3:0]);
    // x stays below (HASH_MUL + 1) * BUCKETS: pick the largest multiple not above it
    x_mod    = x;
    for (int m = 1; m <= int'(HASH_MUL) + 1; m++) begin
      if (x >= XW'(m * BUCKETS)) begin
        x_mod = x - XW'(m * BUCKETS);
      end
    end
  end

  assign done   = busy_r && (k_r == '0);
  assign bucket = h_r;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    h_nxt    = h_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = key;
      h_nxt    = '0;
    end else if (busy_r) begin
      if (k_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = q;
        h_nxt = x_mod[BKT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    k_r <= k_nxt;
    h_r <= h_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/min_value_hash_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_value_hash_map
// Key-to-value map keeping the smallest value seen per key, in a bucketed RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready request beats {action, key, value}. Insert keeps the
//            minimum value per key, find looks a key up, clear empties the
//            table; the unused action code behaves as find.
//   out_ch : exactly one valid/ready result beat {found, stored_value,
//            overflow} per request, in request order.
//   One request is worked at a time. For a find or insert the hash unit
//   peels one decimal digit of the key per cycle (none for key 0, at most
//   10), then the bucket row is read and written back and the result is
//   captured. A clear sweeps every bucket row, one per cycle. After reset
//   the same sweep runs with in_ch.ready low. The result register lets the
//   next request be accepted while a result waits; a result stalled by
//   out_ch.ready holds the next request after its write-back, with
//   in_ch.ready low, until the result register drains.
// ----------------------------------------------------------------------------
module min_value_hash_map #(
  parameter int BUCKETS = 307,
  parameter int WAYS    = 4
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mvhm_in_if.sink     in_ch,
  mvhm_out_if.source  out_ch
);
  import mvhm_pkg::*;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = $bits(entry_t) * WAYS;
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [BKT_W-1:0] clr_addr_r, clr_addr_nxt;

  logic             res_found_r, res_found_nxt;
  logic [VAL_W-1:0] res_value_r, res_value_nxt;
  logic             res_ovf_r, res_ovf_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             in_accept;
  logic             out_free;

  logic             hash_start;
  logic             hash_done;
  logic [BKT_W-1:0] hash_bkt;

  logic             mem_wr_en;
  logic [BKT_W-1:0] mem_wr_addr;
  logic [ROW_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [BKT_W-1:0] mem_rd_addr;
  logic [ROW_W-1:0] mem_rd_data;

  entry_t [WAYS-1:0] rd_row;
  entry_t [WAYS-1:0] mod_row;
  logic              hit, free;
  logic [WAY_W-1:0]  hit_way, free_way;
  logic              mod_we;
  logic              mod_found;
  logic [VAL_W-1:0]  mod_value;
  logic              mod_ovf;

  mvhm_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (in_ch.key),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  mvhm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.stored_value = out_value_r;
  assign out_ch.overflow     = out_ovf_r;

  assign rd_row = mem_rd_data;

  // bucket lookup and row update
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row[w].valid) begin
        if (!hit && rd_row[w].key == key_r) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end

    mod_row   = rd_row;
    mod_we    = 1'b0;
    mod_found = 1'b0;
    mod_value = '0;
    mod_ovf   = 1'b0;
    if (act_r == ACT_INSERT) begin
      if (hit) begin
        mod_we    = 1'b1;
        mod_found = 1'b1;
        mod_value = (val_r < rd_row[hit_way].value) ? val_r : rd_row[hit_way].value;
        mod_row[hit_way].value = mod_value;
      end else if (free) begin
        mod_we    = 1'b1;
        mod_found = 1'b1;
        mod_value = val_r;
        mod_row[free_way] = '{valid: 1'b1, key: key_r, value: val_r};
      end else begin
        mod_ovf = 1'b1;
      end
    end else if (hit) begin
      mod_found = 1'b1;
      mod_value = rd_row[hit_way].value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    clr_addr_nxt  = clr_addr_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    hash_start    = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = hash_bkt;
    mem_wr_data   = mod_row;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = hash_bkt;

    unique case (state_r) inside
      ST_INIT, ST_CLEAR: begin
        // sweep one bucket row per cycle
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr_r;
        mem_wr_data = '0;
        if (clr_addr_r == LAST_BKT) begin
          clr_addr_nxt = '0;
          state_nxt    = (state_r == ST_INIT) ? ST_IDLE : ST_PUSH;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          act_nxt = in_ch.action;
          key_nxt = in_ch.key;
          val_nxt = in_ch.value;
          if (in_ch.action == ACT_CLEAR) begin
            res_found_nxt = 1'b0;
            res_value_nxt = '0;
            res_ovf_nxt   = 1'b0;
            state_nxt     = ST_CLEAR;
          end else begin
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          mem_rd_en = 1'b1;
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        mem_wr_en     = mod_we;
        res_found_nxt = mod_found;
        res_value_nxt = mod_value;
        res_ovf_nxt   = mod_ovf;
        state_nxt     = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_value_nxt = res_value_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // write-back goes to the row read in the cycle before
  a_wb_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY && mem_wr_en) |->
      ($past(mem_rd_en) && $past(mem_rd_addr) == mem_wr_addr))
    else $error("write-back row differs from the row read");

  a_hash_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == ST_HASH))
    else $error("hash finished outside the hash state");

  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.stored_value == '0))
    else $error("absent key reported with a nonzero value");

  a_overflow_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |-> !out_ch.found)
    else $error("overflow reported together with found");

endmodule
`default_nettype wire
